>>> design/integer_set_table_top_assert.svh
// Assertion macros used by the integer set table sequencer (ist_seq).
`ifndef INTEGER_SET_TABLE_TOP_ASSERT_SVH
`define INTEGER_SET_TABLE_TOP_ASSERT_SVH

`ifndef SYNTH

// Property holds at every rising clock edge out of reset.
`define IST_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("integer set table: check failed");

// Consequent holds in the cycle after the antecedent.
`define IST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer set table: check failed");

`else

`define IST_ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define IST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/ist_pkg.sv
package ist_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 2;
    localparam int ST_W         = 3;
    localparam int COUNT_W      = 6;
    localparam int IDX_W        = 6;   // indexes up to 64 entries

    typedef logic [OP_W-1:0]    t_op;
    typedef logic [ST_W-1:0]    t_status;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [DATA_W-1:0]  t_data;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_REMOVE = 2'd1;
    localparam t_op OP_PROBE  = 2'd2;
    localparam t_op OP_DUMP   = 2'd3;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_PRESENT = 3'd1;
    localparam t_status ST_ABSENT  = 3'd2;
    localparam t_status ST_FULL    = 3'd3;
    localparam t_status ST_EMPTY   = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_SHIFT,
        S_DUMP
    } t_state;

    // Probe mark updates, applied by the top level.
    typedef struct packed {
        logic set;
        logic clr_one;
        logic shift;
        logic clr_all;
        t_idx idx;
    } t_mark_ctl;

    // One result beat handed to the output register.
    typedef struct packed {
        logic    valid;
        t_status status;
        logic    found;
        t_data   element;
        logic    is_dump;
        t_idx    idx;
        logic    last;
        t_count  count;
    } t_emit;

endpackage

>>> design/ist_ram.sv
module ist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> design/ist_seq.sv
`include "integer_set_table_top_assert.svh"

module ist_seq #(
    parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  ist_pkg::t_op                  i_operation,
    input  logic signed [ist_pkg::DATA_W-1:0] i_value,
    input  logic                          i_emit_ok,
    input  ist_pkg::t_data                i_rd_data,
    output logic                          o_ram_we,
    output logic [$clog2(CAPACITY)-1:0]   o_ram_waddr,
    output ist_pkg::t_data                o_ram_wdata,
    output logic                          o_ram_re,
    output logic [$clog2(CAPACITY)-1:0]   o_ram_raddr,
    output ist_pkg::t_mark_ctl            o_mark,
    output ist_pkg::t_emit                o_emit
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    ist_pkg::t_state r_state, n_state;
    ist_pkg::t_op    r_op, n_op;
    ist_pkg::t_data  r_val, n_val;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;      // next address to read
    logic            r_pend, n_pend;    // read data for r_cidx arrives this cycle
    logic [AW-1:0]   r_cidx, n_cidx;
    logic            r_found, n_found;
    logic [AW-1:0]   r_slot, n_slot;

    logic          w_acc;
    logic          w_hit;
    logic          w_cidx_last;
    logic          w_more_scan;
    logic          w_more_shift;
    logic          w_full;
    logic          w_dump_go;
    logic [CW-1:0] w_cidx_nx;

    assign o_ready      = (r_state == ist_pkg::S_IDLE);
    assign w_acc        = i_valid && o_ready;
    // the one shared comparator
    assign w_hit        = r_pend && (i_rd_data == r_val);
    assign w_cidx_nx    = CW'(r_cidx) + CW'(1);
    assign w_cidx_last  = r_pend && (w_cidx_nx == r_count);
    assign w_more_scan  = (r_idx < r_count);
    assign w_more_shift = (r_idx <= r_count);
    assign w_full       = (r_count == CW'(CAPACITY));
    assign w_dump_go    = (!r_pend || i_emit_ok) && !w_cidx_last;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ist_pkg::S_IDLE: begin
                if (w_acc) begin
                    if (r_count == '0) begin
                        n_state = ist_pkg::S_ACT;
                    end else if (i_operation == ist_pkg::OP_DUMP) begin
                        n_state = ist_pkg::S_DUMP;
                    end else begin
                        n_state = ist_pkg::S_SCAN;
                    end
                end
            end
            ist_pkg::S_SCAN: begin
                if (w_hit || w_cidx_last) begin
                    n_state = ist_pkg::S_ACT;
                end
            end
            ist_pkg::S_ACT: begin
                if (i_emit_ok) begin
                    n_state = (r_op == ist_pkg::OP_REMOVE && r_found) ?
                              ist_pkg::S_SHIFT : ist_pkg::S_IDLE;
                end
            end
            ist_pkg::S_SHIFT: begin
                if (!w_more_shift && !r_pend) begin
                    n_state = ist_pkg::S_IDLE;
                end
            end
            ist_pkg::S_DUMP: begin
                if (w_cidx_last && i_emit_ok) begin
                    n_state = ist_pkg::S_IDLE;
                end
            end
            default: n_state = ist_pkg::S_IDLE;
        endcase
    end

    // datapath registers
    always_comb begin
        n_op    = r_op;
        n_val   = r_val;
        n_count = r_count;
        n_idx   = r_idx;
        n_pend  = r_pend;
        n_cidx  = r_cidx;
        n_found = r_found;
        n_slot  = r_slot;
        unique case (r_state)
            ist_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_op    = i_operation;
                    n_val   = i_value;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                end
            end
            ist_pkg::S_SCAN: begin
                if (w_hit) begin
                    n_found = 1'b1;
                    n_slot  = r_cidx;
                    n_pend  = 1'b0;
                end else if (w_cidx_last) begin
                    n_pend = 1'b0;
                end else begin
                    n_pend = w_more_scan;
                    n_cidx = r_idx[AW-1:0];
                    if (w_more_scan) begin
                        n_idx = r_idx + CW'(1);
                    end
                end
            end
            ist_pkg::S_ACT: begin
                if (i_emit_ok) begin
                    case (r_op)
                        ist_pkg::OP_INSERT: begin
                            if (!r_found && !w_full) begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        ist_pkg::OP_REMOVE: begin
                            if (r_found) begin
                                n_count = r_count - CW'(1);
                                n_idx   = CW'(r_slot) + CW'(1);
                                n_pend  = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ist_pkg::S_SHIFT: begin
                n_pend = w_more_shift;
                if (w_more_shift) begin
                    n_cidx = r_idx[AW-1:0];
                    n_idx  = r_idx + CW'(1);
                end
            end
            ist_pkg::S_DUMP: begin
                if (w_dump_go) begin
                    n_pend = 1'b1;
                    n_cidx = r_idx[AW-1:0];
                    n_idx  = r_idx + CW'(1);
                end else if (w_cidx_last && i_emit_ok) begin
                    n_pend = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_count[AW-1:0];
        o_ram_wdata = r_val;
        o_ram_re    = 1'b0;
        o_ram_raddr = r_idx[AW-1:0];
        o_mark      = '0;
        o_mark.idx  = ist_pkg::t_idx'(r_slot);
        o_emit         = '0;
        o_emit.element = r_val;
        o_emit.last    = 1'b1;
        o_emit.count   = ist_pkg::t_count'(r_count);
        o_emit.idx     = ist_pkg::t_idx'(r_cidx);
        unique case (r_state)
            ist_pkg::S_IDLE: ;
            ist_pkg::S_SCAN: begin
                o_ram_re = !w_hit && !w_cidx_last && w_more_scan;
            end
            ist_pkg::S_ACT: begin
                o_emit.valid = i_emit_ok;
                case (r_op)
                    ist_pkg::OP_INSERT: begin
                        if (r_found) begin
                            o_emit.status = ist_pkg::ST_PRESENT;
                            o_emit.found  = 1'b1;
                        end else if (w_full) begin
                            o_emit.status = ist_pkg::ST_FULL;
                        end else begin
                            o_emit.status  = ist_pkg::ST_OK;
                            o_emit.count   = ist_pkg::t_count'(r_count + CW'(1));
                            o_ram_we       = i_emit_ok;
                            o_mark.clr_one = i_emit_ok;
                            o_mark.idx     = ist_pkg::t_idx'(r_count);
                        end
                    end
                    ist_pkg::OP_REMOVE: begin
                        if (r_found) begin
                            o_emit.status = ist_pkg::ST_OK;
                            o_emit.found  = 1'b1;
                            o_emit.count  = ist_pkg::t_count'(r_count - CW'(1));
                            o_mark.shift  = i_emit_ok;
                        end else begin
                            o_emit.status = ist_pkg::ST_ABSENT;
                        end
                    end
                    ist_pkg::OP_PROBE: begin
                        if (r_found) begin
                            o_emit.status = ist_pkg::ST_OK;
                            o_emit.found  = 1'b1;
                            o_mark.set    = i_emit_ok;
                        end else begin
                            o_emit.status = ist_pkg::ST_ABSENT;
                        end
                    end
                    ist_pkg::OP_DUMP: begin
                        // only reached on an empty store
                        o_emit.status  = ist_pkg::ST_EMPTY;
                        o_emit.element = '0;
                    end
                    default: ;
                endcase
            end
            ist_pkg::S_SHIFT: begin
                o_ram_re    = w_more_shift;
                o_ram_we    = r_pend;
                o_ram_waddr = r_cidx - AW'(1);
                o_ram_wdata = i_rd_data;
            end
            ist_pkg::S_DUMP: begin
                o_ram_re       = w_dump_go;
                o_emit.valid   = r_pend && i_emit_ok;
                o_emit.status  = ist_pkg::ST_OK;
                o_emit.found   = 1'b1;
                o_emit.element = i_rd_data;
                o_emit.is_dump = 1'b1;
                o_emit.last    = w_cidx_last;
                o_mark.clr_all = w_cidx_last && i_emit_ok;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ist_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_val   <= n_val;
        r_idx   <= n_idx;
        r_cidx  <= n_cidx;
        r_found <= n_found;
        r_slot  <= n_slot;
    end

    `IST_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(CAPACITY))
    `IST_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, o_emit.valid && r_state == ist_pkg::S_ACT && r_op == ist_pkg::OP_INSERT && o_emit.status == ist_pkg::ST_OK, r_count == $past(r_count) + CW'(1))
    `IST_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_acc, r_state != ist_pkg::S_IDLE)
    `IST_ASSERT_NEXT(a_dump_continues, i_clk, i_rst_n, o_emit.valid && !o_emit.last, r_state == ist_pkg::S_DUMP)

endmodule

>>> design/integer_set_table_top.sv
// Integer set table: holds an ordered set of up to CAPACITY distinct signed 32-bit
// values in a single-port-write, registered-read RAM, with one probe mark per entry
// in flip-flops. Insert, remove and probe each walk the stored entries through one
// shared equality comparator, one entry per cycle; a successful remove then closes
// the gap by copying each entry above the removed one down one place through the
// same RAM. Dump streams one beat per entry, at one beat per cycle when the consumer
// keeps up, then clears all marks; on an empty store it gives one "empty" beat.
// The input side is ready only between items; a finished beat sits in the output
// register, so the next item is taken while it waits. No clearing pass is needed
// after reset: only entries that have been written are ever read.
module integer_set_table_top #(
    parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input beats
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ist_pkg::OP_W-1:0]          i_operation,
    input  logic signed [ist_pkg::DATA_W-1:0] i_value,
    // result beats
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ist_pkg::ST_W-1:0]          o_status,
    output logic                              o_found,
    output logic signed [ist_pkg::DATA_W-1:0] o_element,
    output logic                              o_marked,
    output logic                              o_last,
    output logic [ist_pkg::COUNT_W-1:0]       o_count
);

    localparam int AW = $clog2(CAPACITY);

    // RAM port
    logic                   w_ram_we;
    logic [AW-1:0]          w_ram_waddr;
    ist_pkg::t_data         w_ram_wdata;
    logic                   w_ram_re;
    logic [AW-1:0]          w_ram_raddr;
    ist_pkg::t_data         w_rd_data;

    ist_pkg::t_mark_ctl     w_mark;
    ist_pkg::t_emit         w_emit;
    logic                   w_emit_ok;

    logic [CAPACITY-1:0]    r_marks;
    logic [CAPACITY-1:0]    w_marks_shifted;
    logic [AW-1:0]          w_mark_idx;
    logic [AW-1:0]          w_emit_idx;

    logic                   r_out_valid;

    // the output register can take a beat when empty or being drained
    assign w_emit_ok = !r_out_valid || i_ready;

    ist_ram #(
        .WIDTH (ist_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_rd_data)
    );

    ist_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_emit_ok   (w_emit_ok),
        .i_rd_data   (w_rd_data),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .o_mark      (w_mark),
        .o_emit      (w_emit)
    );

    // Probe marks. On remove every mark above the removed slot moves down one
    // place; the topmost keeps its value (cleared when an insert next fills that slot).
    assign w_mark_idx = w_mark.idx[AW-1:0];
    assign w_emit_idx = w_emit.idx[AW-1:0];

    for (genvar k = 0; k < CAPACITY - 1; k++) begin : g_shift
        assign w_marks_shifted[k] = (AW'(k) >= w_mark_idx) ? r_marks[k+1] : r_marks[k];
    end
    assign w_marks_shifted[CAPACITY-1] = r_marks[CAPACITY-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marks <= '0;
        end else if (w_mark.clr_all) begin
            r_marks <= '0;
        end else if (w_mark.set) begin
            r_marks[w_mark_idx] <= 1'b1;
        end else if (w_mark.clr_one) begin
            r_marks[w_mark_idx] <= 1'b0;
        end else if (w_mark.shift) begin
            r_marks <= w_marks_shifted;
        end
    end

    // Output register: a beat waits here for the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.valid) begin
            o_status  <= w_emit.status;
            o_found   <= w_emit.found;
            o_element <= w_emit.element;
            o_marked  <= w_emit.is_dump && r_marks[w_emit_idx];
            o_last    <= w_emit.last;
            o_count   <= w_emit.count;
        end
    end

    assign o_valid = r_out_valid;

endmodule

>>> test/tb_integer_set_table_top.sv
module tb_integer_set_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP         = ist_pkg::CAPACITY_DEF;
    localparam int POOL_SIZE   = 40;      // more than CAP, so a fill runs into a full store
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off, fills the block up
    localparam int TAIL_CYCLES = 100;     // idle tail after the last result, to catch stray beats

    // One request beat as queued for the driver. hold_for_drain makes the sender
    // wait until every outstanding result beat has arrived before offering it.
    typedef struct {
        ist_pkg::t_op   op;
        ist_pkg::t_data value;
        logic           hold_for_drain;
    } t_set_request;

    // One expected result beat.
    typedef struct {
        ist_pkg::t_status status;
        logic             found;
        ist_pkg::t_data   element;
        logic             marked;
        logic             last;
        ist_pkg::t_count  count;
    } t_set_beat;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [ist_pkg::OP_W-1:0] i_operation = ist_pkg::OP_INSERT;
    logic signed [ist_pkg::DATA_W-1:0] i_value = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [ist_pkg::ST_W-1:0] o_status;
    logic                 o_found;
    logic signed [ist_pkg::DATA_W-1:0] o_element;
    logic                 o_marked;
    logic                 o_last;
    logic [ist_pkg::COUNT_W-1:0] o_count;

    integer_set_table_top #(.CAPACITY(CAP)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_element   (o_element),
        .o_marked    (o_marked),
        .o_last      (o_last),
        .o_count     (o_count)
    );

    t_set_request pending_items[$];
    t_set_beat    expected_beats[$];

    // Shadow copy of the set: entries in stored order, one probe mark each.
    ist_pkg::t_data shadow_entries[CAP];
    logic  shadow_marks[CAP];
    int    shadow_count = 0;

    int n_accepted = 0;
    int n_failures = 0;
    int n_cycles   = 0;

    // Window of accepted beats during which neither side idles.
    wire no_idle = (n_accepted >= 100) && (n_accepted < 130);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // count is taken after the state update, as the block reports it
    task automatic push_beat(input ist_pkg::t_status status, input logic found,
                             input ist_pkg::t_data element,
                             input logic marked, input logic last);
        t_set_beat b;
        b.status  = status;
        b.found   = found;
        b.element = element;
        b.marked  = marked;
        b.last    = last;
        b.count   = ist_pkg::t_count'(shadow_count);
        expected_beats.push_back(b);
    endtask

    task automatic predict_set_op(input ist_pkg::t_op op, input ist_pkg::t_data value);
        int slot;
        slot = -1;
        if (op == ist_pkg::OP_DUMP) begin
            if (shadow_count == 0) begin
                push_beat(ist_pkg::ST_EMPTY, 1'b0, '0, 1'b0, 1'b1);
            end else begin
                for (int i = 0; i < shadow_count; i++) begin
                    push_beat(ist_pkg::ST_OK, 1'b1, shadow_entries[i], shadow_marks[i],
                              i == shadow_count - 1);
                end
                for (int i = 0; i < CAP; i++) begin
                    shadow_marks[i] = 1'b0;
                end
            end
            return;
        end
        // first match; entries are distinct anyway
        for (int i = 0; i < shadow_count; i++) begin
            if (slot < 0 && shadow_entries[i] == value) begin
                slot = i;
            end
        end
        case (op)
            ist_pkg::OP_INSERT: begin
                // presence wins over a full store
                if (slot >= 0) begin
                    push_beat(ist_pkg::ST_PRESENT, 1'b1, value, 1'b0, 1'b1);
                end else if (shadow_count >= CAP) begin
                    push_beat(ist_pkg::ST_FULL, 1'b0, value, 1'b0, 1'b1);
                end else begin
                    shadow_entries[shadow_count] = value;
                    shadow_marks[shadow_count]   = 1'b0;
                    shadow_count++;
                    push_beat(ist_pkg::ST_OK, 1'b0, value, 1'b0, 1'b1);
                end
            end
            ist_pkg::OP_REMOVE: begin
                if (slot < 0) begin
                    push_beat(ist_pkg::ST_ABSENT, 1'b0, value, 1'b0, 1'b1);
                end else begin
                    // close the gap; marks travel with their entries
                    for (int i = slot; i + 1 < shadow_count; i++) begin
                        shadow_entries[i] = shadow_entries[i + 1];
                        shadow_marks[i]   = shadow_marks[i + 1];
                    end
                    shadow_count--;
                    push_beat(ist_pkg::ST_OK, 1'b1, value, 1'b0, 1'b1);
                end
            end
            default: begin
                if (slot < 0) begin
                    push_beat(ist_pkg::ST_ABSENT, 1'b0, value, 1'b0, 1'b1);
                end else begin
                    shadow_marks[slot] = 1'b1;
                    push_beat(ist_pkg::ST_OK, 1'b1, value, 1'b0, 1'b1);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued requests; predicts on each accepted beat
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : request_side
        logic held;
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_operation <= ist_pkg::OP_INSERT;
            i_value     <= '0;
        end else begin
            held = i_valid && !o_ready;
            if (i_valid && o_ready) begin
                predict_set_op(i_operation, i_value);
                void'(pending_items.pop_front());
                n_accepted++;
            end
            // a beat on offer stays put until taken; otherwise decide afresh
            if (!held) begin
                if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 30)
                    && (!pending_items[0].hold_for_drain || expected_beats.size() == 0)) begin
                    i_valid     <= 1'b1;
                    i_operation <= pending_items[0].op;
                    i_value     <= pending_items[0].value;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks result beats in order, drives i_ready
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            n_failures++;
        end
    endtask

    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge i_clk) begin : result_side
        t_set_beat want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing outstanding: element %h", o_element);
                    n_failures++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("status",  32'(want.status),  32'(o_status));
                    check_field("found",   32'(want.found),   32'(o_found));
                    check_field("element", want.element,      o_element);
                    check_field("marked",  32'(want.marked),  32'(o_marked));
                    check_field("last",    32'(want.last),    32'(o_last));
                    check_field("count",   32'(want.count),   32'(o_count));
                end
            end
            // one long hold-off mid-fill, so the output register backs up into the input
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!hold_done && n_accepted >= 60) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_ready   <= 1'b0;
            end else begin
                i_ready <= no_idle || ($urandom_range(99) >= 30);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_request(input ist_pkg::t_op op, input ist_pkg::t_data value,
                                 input logic hold_for_drain = 1'b0);
        t_set_request r;
        r.op             = op;
        r.value          = value;
        r.hold_for_drain = hold_for_drain;
        pending_items.push_back(r);
    endtask

    ist_pkg::t_data value_pool[POOL_SIZE];

    initial begin : stimulus
        int             r;
        bit             dup;
        ist_pkg::t_op   op;
        ist_pkg::t_data v;

        // Directed: empty store, extremes, every operation and every outcome but a full store.
        queue_request(ist_pkg::OP_DUMP,   $urandom);              // empty dump
        queue_request(ist_pkg::OP_REMOVE, 32'd5);                 // remove from empty
        queue_request(ist_pkg::OP_PROBE,  32'd7);                 // probe from empty
        queue_request(ist_pkg::OP_INSERT, 32'h8000_0000);
        queue_request(ist_pkg::OP_INSERT, 32'h7fff_ffff);
        queue_request(ist_pkg::OP_INSERT, 32'h0000_0000);
        queue_request(ist_pkg::OP_INSERT, 32'hffff_ffff);
        queue_request(ist_pkg::OP_INSERT, 32'h7fff_ffff);         // already present
        queue_request(ist_pkg::OP_PROBE,  32'h0000_0000);
        queue_request(ist_pkg::OP_PROBE,  32'h0000_0000);         // repeated probe stays marked
        queue_request(ist_pkg::OP_PROBE,  32'h8000_0000);
        queue_request(ist_pkg::OP_PROBE,  32'd12345);             // probe miss
        queue_request(ist_pkg::OP_DUMP,   $urandom);              // shows marks
        queue_request(ist_pkg::OP_DUMP,   $urandom);              // marks now cleared
        queue_request(ist_pkg::OP_PROBE,  32'hffff_ffff);
        queue_request(ist_pkg::OP_REMOVE, 32'h8000_0000);         // head: marks shift down
        queue_request(ist_pkg::OP_REMOVE, 32'hffff_ffff);         // tail: no shift
        queue_request(ist_pkg::OP_REMOVE, 32'd99);                // remove miss
        queue_request(ist_pkg::OP_DUMP,   $urandom);
        queue_request(ist_pkg::OP_REMOVE, 32'h0000_0000);
        queue_request(ist_pkg::OP_REMOVE, 32'h7fff_ffff);         // back to empty
        queue_request(ist_pkg::OP_DUMP,   $urandom);

        // Distinct pool; the extremes are kept in it for the deep states.
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        for (int i = 2; i < POOL_SIZE; i++) begin
            do begin
                v   = $urandom;
                dup = 1'b0;
                for (int j = 0; j < i; j++) begin
                    if (value_pool[j] == v) dup = 1'b1;
                end
            end while (dup);
            value_pool[i] = v;
        end

        // Fill: the whole pool in order, so the store fills and then refuses.
        // The first request waits for the directed part to drain completely.
        for (int i = 0; i < POOL_SIZE; i++) begin
            queue_request(ist_pkg::OP_INSERT, value_pool[i], i == 0);
            if ($urandom_range(99) < 25) begin
                queue_request(ist_pkg::OP_PROBE, value_pool[$urandom_range(POOL_SIZE - 1)]);
            end
        end
        queue_request(ist_pkg::OP_INSERT, value_pool[3]);          // present while full
        queue_request(ist_pkg::OP_DUMP, $urandom);                 // the longest dump

        // Mixed: removal-heavy first, then insertion-heavy; mostly pool values.
        for (int i = 0; i < 90; i++) begin
            r = $urandom_range(99);
            if (i < 45) begin
                op = (r < 45) ? ist_pkg::OP_REMOVE : (r < 67) ? ist_pkg::OP_PROBE :
                     (r < 92) ? ist_pkg::OP_INSERT : ist_pkg::OP_DUMP;
            end else begin
                op = (r < 50) ? ist_pkg::OP_INSERT : (r < 67) ? ist_pkg::OP_REMOVE :
                     (r < 92) ? ist_pkg::OP_PROBE : ist_pkg::OP_DUMP;
            end
            v = ($urandom_range(99) < 80) ? value_pool[$urandom_range(POOL_SIZE - 1)]
                                          : ist_pkg::t_data'($urandom);
            queue_request(op, v);
        end
        queue_request(ist_pkg::OP_DUMP, $urandom);

        // Reset, once.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0) @(posedge i_clk);
        while (expected_beats.size() != 0) @(posedge i_clk);
        // stray beats would show up in this window
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/ist_pkg.sv
design/ist_ram.sv
design/ist_seq.sv
design/integer_set_table_top.sv
test/tb_integer_set_table_top.sv
